// ===== sv/rtu_pkg.sv =====
// rtu_pkg: request codes, word widths, the state update struct and the
// saturation helper shared by the rigid transform unit modules.
// No dependencies.
`default_nettype none

package rtu_pkg;

    localparam int WORD_W = 32;
    localparam int ROWS   = 3;
    // exact sum of three shifted 65-bit products plus a 32-bit term
    localparam int SUM_W  = 67;

    localparam logic [2:0] REQ_LOAD = 3'd0;
    localparam logic [2:0] REQ_FWD  = 3'd1;
    localparam logic [2:0] REQ_INV  = 3'd2;
    localparam logic [2:0] REQ_PRE  = 3'd3;
    localparam logic [2:0] REQ_POST = 3'd4;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic                   rot_we;
        logic [1:0]             row;
        logic [ROWS-1:0][WORD_W-1:0] rot_row;
        logic [ROWS-1:0]        trans_we;
        logic [ROWS-1:0][WORD_W-1:0] trans_val;
    } rtu_upd_t;

    function automatic word_t sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        word_t                   r;
        hi = SUM_W'(signed'(33'sh0_7FFF_FFFF));
        lo = -hi - SUM_W'(1);
        if (v > hi)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < lo)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/rtu_calc.sv =====
// rtu_calc: combinational datapath for one request: nine products, the
// row sums with saturation and the next translation / matrix row.
// Depends on rtu_pkg.
`default_nettype none

module rtu_calc #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                             active,
    input  wire logic [2:0]                                       req,
    input  wire logic [1:0]                                       row,
    input  wire logic [rtu_pkg::WORD_W-1:0]                       px,
    input  wire logic [rtu_pkg::WORD_W-1:0]                       py,
    input  wire logic [rtu_pkg::WORD_W-1:0]                       pz,
    input  wire logic [rtu_pkg::WORD_W-1:0]                       pw,
    input  wire logic [8:0][rtu_pkg::WORD_W-1:0]                  rot,
    input  wire logic [rtu_pkg::ROWS-1:0][rtu_pkg::WORD_W-1:0]    trans,
    output logic      [rtu_pkg::ROWS-1:0][rtu_pkg::WORD_W-1:0]    res,
    output logic                                                  has_result,
    output rtu_pkg::rtu_upd_t                                     upd
);

    localparam int SW = rtu_pkg::SUM_W;

    logic [rtu_pkg::ROWS-1:0][rtu_pkg::WORD_W-1:0] p;
    logic signed [32:0]     a [rtu_pkg::ROWS];
    logic signed [64:0]     prod [rtu_pkg::ROWS][rtu_pkg::ROWS];
    logic signed [SW-1:0]   sum [rtu_pkg::ROWS];
    logic [rtu_pkg::ROWS-1:0][rtu_pkg::WORD_W-1:0] pre_t;
    logic [rtu_pkg::ROWS-1:0] row_hot;
    logic                   inv;
    logic                   add_t;

    assign p   = {pz, py, px};
    assign inv = (req == rtu_pkg::REQ_INV);
    assign add_t = (req == rtu_pkg::REQ_FWD) || (req == rtu_pkg::REQ_POST);

    genvar i, j;
    generate
        for (i = 0; i < rtu_pkg::ROWS; i++)
        begin : g_row
            // inverse works on p - t at 33 bits, exact
            assign a[i] = inv ? (33'(signed'(p[i])) - 33'(signed'(trans[i])))
                              : 33'(signed'(p[i]));
            for (j = 0; j < rtu_pkg::ROWS; j++)
            begin : g_col
                // inverse reads the transposed matrix
                assign prod[i][j] = 65'(signed'(inv ? rot[j*3+i] : rot[i*3+j])) * a[j];
            end
            assign sum[i] = SW'(prod[i][0] >>> FRAC_BITS)
                          + SW'(prod[i][1] >>> FRAC_BITS)
                          + SW'(prod[i][2] >>> FRAC_BITS)
                          + (add_t ? SW'(signed'(trans[i])) : SW'(0));
            assign res[i]   = rtu_pkg::sat32(sum[i]);
            assign pre_t[i] = rtu_pkg::sat32(SW'(signed'(trans[i])) + SW'(signed'(p[i])));
            assign row_hot[i] = (row == 2'(i));
        end
    endgenerate

    always_comb
    begin
        has_result   = 1'b0;
        upd.rot_we   = 1'b0;
        upd.row      = row;
        upd.rot_row  = p;
        upd.trans_we = '0;
        upd.trans_val = res;
        unique case (req)
            rtu_pkg::REQ_LOAD:
            begin
                // a load to row three falls through with no write
                upd.rot_we    = active && (row_hot != '0);
                upd.trans_we  = active ? row_hot : '0;
                upd.trans_val = {pw, pw, pw};
            end
            rtu_pkg::REQ_FWD, rtu_pkg::REQ_INV:
            begin
                has_result = 1'b1;
            end
            rtu_pkg::REQ_PRE:
            begin
                upd.trans_we  = {rtu_pkg::ROWS{active}};
                upd.trans_val = pre_t;
            end
            rtu_pkg::REQ_POST:
            begin
                upd.trans_we  = {rtu_pkg::ROWS{active}};
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/rtu_regs.sv =====
// rtu_regs: rotation and translation registers of the held transform,
// identity after reset, written from the update struct.
// Depends on rtu_pkg.
`default_nettype none

module rtu_regs #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire rtu_pkg::rtu_upd_t                             upd,
    output logic [8:0][rtu_pkg::WORD_W-1:0]                    rot,
    output logic [rtu_pkg::ROWS-1:0][rtu_pkg::WORD_W-1:0]      trans
);

    localparam logic [rtu_pkg::WORD_W-1:0] ONE = rtu_pkg::WORD_W'(1) << FRAC_BITS;
    localparam logic [rtu_pkg::WORD_W-1:0] ZERO = '0;
    // identity, row major
    localparam logic [8:0][rtu_pkg::WORD_W-1:0] ROT_RESET =
        {ONE, ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE};

    logic [8:0][rtu_pkg::WORD_W-1:0]               rot_reg;
    logic [rtu_pkg::ROWS-1:0][rtu_pkg::WORD_W-1:0] trans_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg   <= ROT_RESET;
            trans_reg <= '0;
        end
        else
        begin
            for (int r = 0; r < rtu_pkg::ROWS; r++)
            begin
                if (upd.rot_we && (upd.row == 2'(r)))
                begin
                    for (int c = 0; c < rtu_pkg::ROWS; c++)
                    begin
                        rot_reg[r*3+c] <= upd.rot_row[c];
                    end
                end
                if (upd.trans_we[r])
                begin
                    trans_reg[r] <= upd.trans_val[r];
                end
            end
        end
    end

    assign rot   = rot_reg;
    assign trans = trans_reg;

endmodule

`default_nettype wire

// ===== sv/rigid_transform_unit_top.sv =====
// rigid_transform_unit_top: input register, transform datapath and
// result register around the held rigid transform.
// Depends on rtu_pkg, rtu_calc and rtu_regs.
//
//   channel | handshake          | word
//   --------+--------------------+-------------------------------------
//   input   | in_valid/in_ready  | req_type, row_index, x, y, z, w
//   output  | out_valid/out_ready| out_x, out_y, out_z
//
// one word per cycle sustained while no transform word waits on a held result;
// a word is held in the input register until it leaves, and a transform result
// is loaded into the output register as its word leaves, which raises out_valid.
// matrix updates commit as the word leaves the input register, so the next
// word already sees them. reset loads the identity and zero translation.
// a held result stalls only transform words; other requests keep flowing.
`default_nettype none

module rigid_transform_unit_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  req_type,
    input  wire logic [1:0]  row_index,
    input  wire logic [31:0] x,
    input  wire logic [31:0] y,
    input  wire logic [31:0] z,
    input  wire logic [31:0] w,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_x,
    output logic [31:0]      out_y,
    output logic [31:0]      out_z
);

    logic        s1_valid_reg;
    logic [2:0]  s1_req_reg;
    logic [1:0]  s1_row_reg;
    logic [31:0] s1_x_reg;
    logic [31:0] s1_y_reg;
    logic [31:0] s1_z_reg;
    logic [31:0] s1_w_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [rtu_pkg::ROWS-1:0][31:0] out_reg;

    logic        s1_fire;
    logic        s1_has_result;
    logic        in_fire;
    logic [rtu_pkg::ROWS-1:0][31:0] res;
    logic [8:0][31:0]               rot;
    logic [rtu_pkg::ROWS-1:0][31:0] trans;
    rtu_pkg::rtu_upd_t              upd;

    rtu_calc #(.FRAC_BITS(FRAC_BITS)) u_calc (
        .active     (s1_fire),
        .req        (s1_req_reg),
        .row        (s1_row_reg),
        .px         (s1_x_reg),
        .py         (s1_y_reg),
        .pz         (s1_z_reg),
        .pw         (s1_w_reg),
        .rot        (rot),
        .trans      (trans),
        .res        (res),
        .has_result (s1_has_result),
        .upd        (upd)
    );

    rtu_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .rot   (rot),
        .trans (trans)
    );

    // only a transform word needs a free output slot
    assign s1_fire  = s1_valid_reg && (!s1_has_result || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        priority if (s1_fire && s1_has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_fire || (s1_valid_reg && !s1_fire);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_reg <= req_type;
            s1_row_reg <= row_index;
            s1_x_reg   <= x;
            s1_y_reg   <= y;
            s1_z_reg   <= z;
            s1_w_reg   <= w;
        end
        if (s1_fire && s1_has_result)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];
    assign out_z     = out_reg[2];

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_has_result |=> out_valid_reg)
        else $error("transform word left the input register without a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(s1_fire && s1_has_result))
        else $error("held result overwritten");

    a_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_req_reg))
        else $error("stalled word lost from the input register");

endmodule

`default_nettype wire

// ===== tb/rigid_transform_unit_top_tb.sv =====
// rigid_transform_unit_top_tb: drives request words into the rigid transform unit,
// predicts each forward and inverse result in fixed point and checks it in order.
// Depends on rtu_pkg and rigid_transform_unit_top.
`default_nettype none

module rigid_transform_unit_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef rtu_pkg::word_t word_t;

    localparam int FRAC          = 16;
    localparam int N_ITEMS       = 1750;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT       = 300;
    localparam int QUIET_FROM    = 600;
    localparam int QUIET_TO      = 900;
    localparam int PAUSE_AT      = 1100;

    localparam logic [2:0]  REQ_UNUSED_FIRST = 3'd5;
    localparam logic [1:0]  ROW_NONE         = 2'd3;
    localparam word_t       WORD_MAX         = 32'h7FFF_FFFF;
    localparam word_t       WORD_MIN         = 32'h8000_0000;
    localparam word_t       UNIT             = word_t'(1) << FRAC;

    typedef logic signed [rtu_pkg::SUM_W-1:0] wide_t;

    typedef struct {
        logic [2:0] req;
        logic [1:0] row;
        word_t      x;
        word_t      y;
        word_t      z;
        word_t      w;
        bit         typed;
        word_t      ex;
        word_t      ey;
        word_t      ez;
    } request_t;

    typedef struct {
        word_t x;
        word_t y;
        word_t z;
    } point_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  req_type;
    logic [1:0]  row_index;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;

    // predictor state: rotation row major, translation per row
    logic signed [31:0] rot_m [9];
    logic signed [31:0] trans_v [3];

    point_t   expected_points [$];
    request_t directed [$];
    int       errors = 0;
    int       cycles = 0;
    int       sent = 0;
    bit       quiet = 1'b0;
    bit       hold_req = 1'b0;
    bit       hold_done = 1'b0;
    int       hold_left = 0;

    rigid_transform_unit_top #(
        .FRAC_BITS(FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .row_index (row_index),
        .x         (x),
        .y         (y),
        .z         (z),
        .w         (w),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // exact product, floor-shifted by the fraction bits
    function automatic wide_t trunc_mul(input logic signed [31:0] a,
                                        input logic signed [32:0] b);
        wide_t pa;
        wide_t pb;
        pa = a;
        pb = b;
        return (pa * pb) >>> FRAC;
    endfunction

    function automatic word_t clamp_word(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = 2147483647;
        lo = -hi - 1;
        if (v > hi)
            return WORD_MAX;
        else if (v < lo)
            return WORD_MIN;
        else
            return v[31:0];
    endfunction

    function automatic bit is_ignored(input request_t r);
        return (r.req >= REQ_UNUSED_FIRST)
            || (r.req == rtu_pkg::REQ_LOAD && r.row == ROW_NONE);
    endfunction

    task automatic predict_transform(input request_t r, output bit gives, output point_t res);
        logic signed [32:0] p [3];
        logic signed [32:0] dv [3];
        wide_t              acc [3];
        wide_t              tw;
        int                 i;
        p[0] = signed'(r.x);
        p[1] = signed'(r.y);
        p[2] = signed'(r.z);
        gives = 1'b0;
        res = '{default: '0};
        case (r.req)
            rtu_pkg::REQ_LOAD:
            begin
                if (r.row != ROW_NONE)
                begin
                    rot_m[r.row*3+0] = r.x;
                    rot_m[r.row*3+1] = r.y;
                    rot_m[r.row*3+2] = r.z;
                    trans_v[r.row]   = r.w;
                end
            end
            rtu_pkg::REQ_FWD:
            begin
                for (i = 0; i < 3; i++)
                begin
                    tw = trans_v[i];
                    acc[i] = trunc_mul(rot_m[i*3+0], p[0]) + trunc_mul(rot_m[i*3+1], p[1])
                           + trunc_mul(rot_m[i*3+2], p[2]) + tw;
                end
                gives = 1'b1;
            end
            rtu_pkg::REQ_INV:
            begin
                for (i = 0; i < 3; i++)
                    dv[i] = p[i] - trans_v[i];
                // transposed rotation: walk down the columns
                for (i = 0; i < 3; i++)
                    acc[i] = trunc_mul(rot_m[0*3+i], dv[0]) + trunc_mul(rot_m[1*3+i], dv[1])
                           + trunc_mul(rot_m[2*3+i], dv[2]);
                gives = 1'b1;
            end
            rtu_pkg::REQ_PRE:
            begin
                for (i = 0; i < 3; i++)
                begin
                    tw = trans_v[i];
                    trans_v[i] = clamp_word(tw + p[i]);
                end
            end
            rtu_pkg::REQ_POST:
            begin
                for (i = 0; i < 3; i++)
                begin
                    tw = trans_v[i];
                    trans_v[i] = clamp_word(trunc_mul(rot_m[i*3+0], p[0])
                                          + trunc_mul(rot_m[i*3+1], p[1])
                                          + trunc_mul(rot_m[i*3+2], p[2]) + tw);
                end
            end
            default:
            begin
            end
        endcase
        if (gives)
        begin
            res.x = clamp_word(acc[0]);
            res.y = clamp_word(acc[1]);
            res.z = clamp_word(acc[2]);
        end
    endtask

    task automatic add_dir(input logic [2:0] req, input logic [1:0] row,
                           input word_t vx, input word_t vy, input word_t vz, input word_t vw,
                           input bit typed, input word_t ex, input word_t ey, input word_t ez);
        request_t r;
        r = '{req, row, vx, vy, vz, vw, typed, ex, ey, ez};
        directed.push_back(r);
    endtask

    function automatic word_t rand_word(input bit rot_like);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return WORD_MAX;
        else if (k == 1)
            return WORD_MIN;
        else if (k < 4)
            return $urandom();
        else if (rot_like)
            return word_t'($urandom_range(0, 2 * UNIT)) - UNIT;
        else
            return word_t'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endfunction

    function automatic request_t make_random();
        request_t r;
        int       k;
        bit       is_load;
        k = $urandom_range(0, 99);
        if (k < 18)
            r.req = rtu_pkg::REQ_LOAD;
        else if (k < 48)
            r.req = rtu_pkg::REQ_FWD;
        else if (k < 78)
            r.req = rtu_pkg::REQ_INV;
        else if (k < 86)
            r.req = rtu_pkg::REQ_PRE;
        else if (k < 94)
            r.req = rtu_pkg::REQ_POST;
        else
            r.req = REQ_UNUSED_FIRST + 3'($urandom_range(0, 2));
        is_load = (r.req == rtu_pkg::REQ_LOAD);
        if (is_load && $urandom_range(0, 9) != 0)
            r.row = 2'($urandom_range(0, 2));
        else
            r.row = 2'($urandom_range(0, 3));
        r.x = rand_word(is_load);
        r.y = rand_word(is_load);
        r.z = rand_word(is_load);
        r.w = is_load ? rand_word(1'b0) : $urandom();
        r.typed = 1'b0;
        r.ex = '0;
        r.ey = '0;
        r.ez = '0;
        return r;
    endfunction

    function automatic int idle_gap();
        int n;
        n = 0;
        if (!quiet)
            while (n < 20 && $urandom_range(0, 99) < 16)
                n++;
        return n;
    endfunction

    task automatic send_word(input request_t r);
        int     gap;
        bit     gives;
        point_t res;
        gap = idle_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_type  <= r.req;
        row_index <= r.row;
        x         <= r.x;
        y         <= r.y;
        z         <= r.z;
        w         <= r.w;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_transform(r, gives, res);
        if (gives)
        begin
            if (r.typed)
                res = '{r.ex, r.ey, r.ez};
            expected_points.push_back(res);
        end
        if (!is_ignored(r))
            sent++;
    endtask

    // receiver: random stalls, one long hold-off while the sender keeps going
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                hold_left <= HOLD_CYCLES - 1;
                hold_done <= 1'b1;
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        point_t exp_p;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: %0d %0d %0d",
                             $signed(out_x), $signed(out_y), $signed(out_z));
            end
            else
            begin
                exp_p = expected_points.pop_front();
                if (out_x !== exp_p.x || out_y !== exp_p.y || out_z !== exp_p.z)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at cycle %0d: expected %0d %0d %0d, got %0d %0d %0d",
                                 cycles, $signed(exp_p.x), $signed(exp_p.y), $signed(exp_p.z),
                                 $signed(out_x), $signed(out_y), $signed(out_z));
                end
            end
        end
    end

    initial
    begin
        int i;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = rtu_pkg::REQ_LOAD;
        row_index = '0;
        x         = '0;
        y         = '0;
        z         = '0;
        w         = '0;
        for (i = 0; i < 9; i++)
            rot_m[i] = (i % 4 == 0) ? signed'(UNIT) : 32'sd0;
        for (i = 0; i < 3; i++)
            trans_v[i] = '0;

        // identity after reset passes points through unchanged
        add_dir(rtu_pkg::REQ_FWD, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1, 32'd0, 32'd0, 32'd0);
        add_dir(rtu_pkg::REQ_FWD, 2'd3, WORD_MAX, WORD_MIN, 32'd1, WORD_MAX,
                1, WORD_MAX, WORD_MIN, 32'd1);
        add_dir(rtu_pkg::REQ_INV, 2'd1, WORD_MIN, WORD_MAX, 32'hFFFF_FFFF, WORD_MIN,
                1, WORD_MIN, WORD_MAX, 32'hFFFF_FFFF);
        add_dir(rtu_pkg::REQ_LOAD, 2'd0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_LOAD, 2'd1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_LOAD, 2'd2, UNIT, -UNIT, 32'd0, 32'h1234_5678, 0, '0, '0, '0);
        // row three is dropped
        add_dir(rtu_pkg::REQ_LOAD, ROW_NONE, 32'hDEAD_BEEF, 32'h1, 32'h2, 32'h3,
                0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_FWD, 2'd0, WORD_MAX, WORD_MAX, WORD_MAX, 32'd0,
                1, WORD_MAX, WORD_MIN, 32'h1234_5678);
        add_dir(rtu_pkg::REQ_INV, 2'd0, WORD_MIN, WORD_MIN, WORD_MIN, 32'd0, 0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_FWD, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5,
                0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_PRE, 2'd0, WORD_MAX, WORD_MAX, WORD_MAX, 32'd0, 0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_FWD, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_PRE, 2'd3, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX,
                0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_POST, 2'd1, UNIT, 32'd1, 32'hFFFF_FFFF, 32'd0, 0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_INV, 2'd3, 32'd12345, -32'd777, 32'd0, WORD_MIN,
                0, '0, '0, '0);
        add_dir(REQ_UNUSED_FIRST, 2'd1, WORD_MAX, 32'd0, 32'd0, 32'd0, 0, '0, '0, '0);
        add_dir(REQ_UNUSED_FIRST + 3'd1, 2'd2, 32'd0, WORD_MIN, 32'd0, 32'd0, 0, '0, '0, '0);
        add_dir(REQ_UNUSED_FIRST + 3'd2, 2'd3, $urandom(), $urandom(), $urandom(), $urandom(),
                0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_FWD, 2'd1, 32'd65536, 32'd65536, 32'd65536, 32'hFFFF_FFFF,
                0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_LOAD, 2'd0, UNIT, 32'd0, 32'd0, 32'd0, 0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_LOAD, 2'd1, 32'd0, UNIT, 32'd0, 32'd0, 0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_LOAD, 2'd2, 32'd0, 32'd0, UNIT, 32'd0, 0, '0, '0, '0);
        add_dir(rtu_pkg::REQ_FWD, 2'd0, 32'h0001_2345, -32'h6789, 32'd7, 32'd0,
                1, 32'h0001_2345, -32'h6789, 32'd7);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < directed.size(); i++)
            send_word(directed[i]);

        while (sent < N_ITEMS)
        begin
            if (sent == HOLD_AT)
                hold_req = 1'b1;
            quiet = (sent >= QUIET_FROM && sent < QUIET_TO);
            if (sent == PAUSE_AT)
            begin
                // let every pending result drain before going on
                @(negedge clk);
                in_valid <= 1'b0;
                wait (expected_points.size() == 0);
            end
            send_word(make_random());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait (expected_points.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_points.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/rtu_pkg.sv
sv/rtu_calc.sv
sv/rtu_regs.sv
sv/rigid_transform_unit_top.sv
tb/rigid_transform_unit_top_tb.sv
